// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the bit field copy block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define BEF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define BEF_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/bef_pkg.sv -----
// ----------------------------------------------------------------------------
// bef_pkg
// shared types and constants of the bit field copy block
// ----------------------------------------------------------------------------
package bef_pkg;

	localparam int BUF_BYTES = 32;
	localparam int BUF_AW    = $clog2(BUF_BYTES);
	localparam int QDEPTH    = 2;
	localparam int QAW       = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		REQ_WR_SRC = 2'd0,
		REQ_WR_DST = 2'd1,
		REQ_COPY   = 2'd2,
		REQ_RD_DST = 2'd3
	} req_t;

	// classified request handed from front to back
	typedef struct packed {
		req_t       req;
		logic [4:0] idx;
		logic [7:0] data;
		logic [8:0] sbits;
		logic [7:0] sstart;
		logic [1:0] sord;
		logic [8:0] dbits;
		logic [1:0] dord;
		logic [8:0] n;
		logic       rev;
		logic [9:0] tstart;
	} cmd_t;

endpackage

// ----- rtl/core/bitwise_endian_field_copy.sv -----
// ----------------------------------------------------------------------------
// bitwise_endian_field_copy
// bit field copy between two byte stores with per-field bit and byte order
// ----------------------------------------------------------------------------
// requests enter through push/full, one per cycle while full is low, and
// land in a two entry request queue. results leave through empty/pop, one
// result per request, in request order, held in a single output register.
// a byte write or byte read pushed at one edge shows its result at the
// next edge when nothing waits. a copy of n bits occupies the back end
// through its copy and drain states, one bit per cycle through a read
// stage on the source store and a bit write on the destination store;
// the front queue keeps taking requests meanwhile until it fills.
// while a result waits unpopped the back end takes no new request, the
// queue fills and full rises. reset empties the queue and
// the result register; the two byte stores hold no defined value until
// written.
// ----------------------------------------------------------------------------
module bitwise_endian_field_copy (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] req_type,
	input  logic [4:0] byte_index,
	input  logic [7:0] byte_data,
	input  logic [8:0] src_bits,
	input  logic [7:0] src_start,
	input  logic [1:0] src_order,
	input  logic [8:0] dst_bits,
	input  logic [7:0] dst_start,
	input  logic [1:0] dst_order,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] read_data,
	output logic [8:0] bits_copied
);

	logic          cmd_valid;
	logic          cmd_take;
	bef_pkg::cmd_t cmd;

	bef_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.req_type   (req_type),
		.byte_index (byte_index),
		.byte_data  (byte_data),
		.src_bits   (src_bits),
		.src_start  (src_start),
		.src_order  (src_order),
		.dst_bits   (dst_bits),
		.dst_start  (dst_start),
		.dst_order  (dst_order),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_take   (cmd_take)
	);

	bef_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_take    (cmd_take),
		.empty       (empty),
		.pop         (pop),
		.read_data   (read_data),
		.bits_copied (bits_copied)
	);

endmodule

// ----- rtl/core/bef_front.sv -----
// ----------------------------------------------------------------------------
// bef_front
// accepts requests, works out copy length and direction, and queues them
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bef_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [1:0]    req_type,
	input  logic [4:0]    byte_index,
	input  logic [7:0]    byte_data,
	input  logic [8:0]    src_bits,
	input  logic [7:0]    src_start,
	input  logic [1:0]    src_order,
	input  logic [8:0]    dst_bits,
	input  logic [7:0]    dst_start,
	input  logic [1:0]    dst_order,
	output logic          cmd_valid,
	output bef_pkg::cmd_t cmd,
	input  logic          cmd_take
);

	bef_pkg::cmd_t        queue_q [bef_pkg::QDEPTH];
	logic [bef_pkg::QAW-1:0] wr_ptr_q;
	logic [bef_pkg::QAW-1:0] rd_ptr_q;
	logic [bef_pkg::QAW:0]   cnt_q;

	logic signed [9:0] sleft;
	logic signed [9:0] dleft;
	logic signed [9:0] nmin;
	logic              rev;
	bef_pkg::cmd_t     cmd_in;
	logic              do_push;

	assign sleft = $signed({1'b0, src_bits}) - $signed({2'b00, src_start});
	assign dleft = $signed({1'b0, dst_bits}) - $signed({2'b00, dst_start});
	assign nmin  = (sleft < dleft) ? sleft : dleft;
	assign rev   = src_order[1] ^ dst_order[1];

	always_comb begin
		cmd_in.req    = bef_pkg::req_t'(req_type);
		cmd_in.idx    = byte_index;
		cmd_in.data   = byte_data;
		cmd_in.sbits  = src_bits;
		cmd_in.sstart = src_start;
		cmd_in.sord   = src_order;
		cmd_in.dbits  = dst_bits;
		cmd_in.dord   = dst_order;
		cmd_in.n      = nmin[9] ? 9'd0 : nmin[8:0];
		cmd_in.rev    = rev;
		// reversed copy walks the destination downward from its far end
		cmd_in.tstart = rev ? ({2'b00, dst_start} + $unsigned(sleft) - 10'd1)
			: {2'b00, dst_start};
	end

	assign full      = (cnt_q == (bef_pkg::QAW+1)'(bef_pkg::QDEPTH));
	assign do_push   = push && !full;
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			queue_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (cmd_take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, cmd_take})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`BEF_ASSERT(a_take_needs_entry, cmd_take |-> (cnt_q != '0), "request taken from empty queue")

endmodule

// ----- rtl/core/bef_back.sv -----
// ----------------------------------------------------------------------------
// bef_back
// holds both byte stores, runs byte requests and the bit serial copy,
// and keeps the result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bef_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  bef_pkg::cmd_t cmd,
	output logic          cmd_take,
	output logic          empty,
	input  logic          pop,
	output logic [7:0]    read_data,
	output logic [8:0]    bits_copied
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_COPY,
		S_DRAIN
	} state_t;

	typedef struct packed {
		logic                    ok;
		logic [bef_pkg::BUF_AW-1:0] addr;
		logic [2:0]              bpos;
	} map_t;

	function automatic map_t map_bit(logic [8:0] bits, logic [9:0] pos, logic [1:0] order);
		logic [6:0] size;
		logic [6:0] raw;
		logic [7:0] idx;
		map_t       m;
		size   = 7'(({1'b0, bits} + 10'd7) >> 3);
		raw    = pos[9:3];
		idx    = order[0] ? ({1'b0, size} - 8'd1 - {1'b0, raw}) : {1'b0, raw};
		m.ok   = (pos < {1'b0, bits}) && !idx[7] && (idx < 8'(bef_pkg::BUF_BYTES));
		m.addr = idx[bef_pkg::BUF_AW-1:0];
		m.bpos = order[1] ? ~pos[2:0] : pos[2:0];
		return m;
	endfunction

	logic [7:0] src_mem [bef_pkg::BUF_BYTES];
	logic [7:0] dst_mem [bef_pkg::BUF_BYTES];

	state_t     state_q;
	logic       res_valid_q;
	logic [7:0] res_rd_q;
	logic [8:0] res_bc_q;

	logic [8:0] sbits_q;
	logic [1:0] sord_q;
	logic [8:0] dbits_q;
	logic [1:0] dord_q;
	logic       rev_q;
	logic [8:0] n_q;
	logic [8:0] spos_q;
	logic [9:0] tpos_q;
	logic [8:0] cnt_q;

	logic       vld_s1;
	logic [7:0] src_rd_s1;
	logic       sok_s1;
	logic [2:0] sbit_s1;
	logic       dok_s1;
	logic [bef_pkg::BUF_AW-1:0] dbyte_s1;
	logic [2:0] dbit_s1;

	map_t       smap;
	map_t       dmap;
	logic       idx_ok;

	assign smap     = map_bit(sbits_q, {1'b0, spos_q}, sord_q);
	assign dmap     = map_bit(dbits_q, tpos_q, dord_q);
	assign idx_ok   = (32'(cmd.idx) < bef_pkg::BUF_BYTES);
	assign cmd_take = (state_q == S_IDLE) && cmd_valid && (!res_valid_q || pop);

	assign empty       = !res_valid_q;
	assign read_data   = res_rd_q;
	assign bits_copied = res_bc_q;

	// source store and its registered read port
	always_ff @(posedge clk) begin
		if (cmd_take && (cmd.req == bef_pkg::REQ_WR_SRC) && idx_ok) begin
			src_mem[cmd.idx[bef_pkg::BUF_AW-1:0]] <= cmd.data;
		end
		src_rd_s1 <= src_mem[smap.addr];
	end

	// destination store: byte writes and single bit writes of the copy
	always_ff @(posedge clk) begin
		if (cmd_take && (cmd.req == bef_pkg::REQ_WR_DST) && idx_ok) begin
			dst_mem[cmd.idx[bef_pkg::BUF_AW-1:0]] <= cmd.data;
		end else if (vld_s1 && dok_s1) begin
			dst_mem[dbyte_s1][dbit_s1] <= sok_s1 & src_rd_s1[sbit_s1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			res_rd_q    <= '0;
			res_bc_q    <= '0;
			vld_s1      <= 1'b0;
			sbits_q     <= '0;
			sord_q      <= '0;
			dbits_q     <= '0;
			dord_q      <= '0;
			rev_q       <= 1'b0;
			n_q         <= '0;
			spos_q      <= '0;
			tpos_q      <= '0;
			cnt_q       <= '0;
			sok_s1      <= 1'b0;
			sbit_s1     <= '0;
			dok_s1      <= 1'b0;
			dbyte_s1    <= '0;
			dbit_s1     <= '0;
		end else begin
			vld_s1   <= (state_q == S_COPY);
			sok_s1   <= smap.ok;
			sbit_s1  <= smap.bpos;
			dok_s1   <= dmap.ok;
			dbyte_s1 <= dmap.addr;
			dbit_s1  <= dmap.bpos;
			case (state_q)
				S_IDLE: begin
					if (cmd_take) begin
						res_rd_q <= ((cmd.req == bef_pkg::REQ_RD_DST) && idx_ok) ?
							dst_mem[cmd.idx[bef_pkg::BUF_AW-1:0]] : 8'd0;
						res_bc_q <= '0;
						case (cmd.req)
							bef_pkg::REQ_WR_SRC,
							bef_pkg::REQ_WR_DST: begin
								res_valid_q <= 1'b1;
							end
							bef_pkg::REQ_RD_DST: begin
								res_valid_q <= 1'b1;
							end
							bef_pkg::REQ_COPY: begin
								if (cmd.n == '0) begin
									res_valid_q <= 1'b1;
								end else begin
									res_valid_q <= 1'b0;
									sbits_q     <= cmd.sbits;
									sord_q      <= cmd.sord;
									dbits_q     <= cmd.dbits;
									dord_q      <= cmd.dord;
									rev_q       <= cmd.rev;
									n_q         <= cmd.n;
									spos_q      <= {1'b0, cmd.sstart};
									tpos_q      <= cmd.tstart;
									cnt_q       <= cmd.n;
									state_q     <= S_COPY;
								end
							end
							default: begin
								res_valid_q <= 1'b1;
							end
						endcase
					end else if (pop) begin
						res_valid_q <= 1'b0;
					end
				end
				S_COPY: begin
					spos_q <= spos_q + 9'd1;
					tpos_q <= rev_q ? (tpos_q - 10'd1) : (tpos_q + 10'd1);
					cnt_q  <= cnt_q - 9'd1;
					if (cnt_q == 9'd1) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					res_valid_q <= 1'b1;
					res_rd_q    <= '0;
					res_bc_q    <= n_q;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`BEF_ASSERT(a_copy_slot_free, (state_q != S_IDLE) |-> !res_valid_q, "result slot busy during copy")
	`BEF_ASSERT(a_copy_count_live, (state_q == S_COPY) |-> (cnt_q != '0), "copy running with no bits left")
	`BEF_ASSERT(a_bit_write_in_copy, vld_s1 |-> ((state_q == S_COPY) || (state_q == S_DRAIN)), "bit write outside copy")
	`BEF_ASSERT(a_drain_result, (state_q == S_DRAIN) |=> (res_valid_q && (res_bc_q == $past(n_q))), "copy result lost")

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the bit field copy block
// ----------------------------------------------------------------------------
// both byte stores are loaded in full first, so no request ever touches an
// unwritten byte. a table of directed requests follows, then random requests
// of all kinds with random orders and contents, copies mostly short fields.
// each accepted request runs through a local bit-level predictor, and each
// popped result is compared with the oldest prediction. the sender runs in
// bursts with gaps, the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int IDLE_LIMIT = 6000;
	localparam int RAND_REQS  = 800;

	typedef struct packed {
		bef_pkg::req_t req;
		logic [4:0] idx;
		logic [7:0] data;
		logic [8:0] sbits;
		logic [7:0] sstart;
		logic [1:0] sord;
		logic [8:0] dbits;
		logic [7:0] dstart;
		logic [1:0] dord;
		logic       known;
		logic [7:0] rd;
		logic [8:0] nc;
	} fc_req_t;

	typedef struct packed {
		logic [7:0] rd;
		logic [8:0] nc;
	} fc_result_t;

	logic       clk;
	logic       arst_n;
	logic       push = 1'b0;
	logic       full;
	logic [1:0] req_type = '0;
	logic [4:0] byte_index = '0;
	logic [7:0] byte_data = '0;
	logic [8:0] src_bits = '0;
	logic [7:0] src_start = '0;
	logic [1:0] src_order = '0;
	logic [8:0] dst_bits = '0;
	logic [7:0] dst_start = '0;
	logic [1:0] dst_order = '0;
	logic       empty;
	logic       pop = 1'b0;
	logic [7:0] read_data;
	logic [8:0] bits_copied;

	logic [7:0] src_mem [bef_pkg::BUF_BYTES];
	logic [7:0] dst_mem [bef_pkg::BUF_BYTES];
	fc_result_t pending_results [$];
	int         errors = 0;
	int         idle_cycles = 0;
	int         burst_left = 0;
	int         stall_left = 0;
	int         pop_mode = 0;
	int         mode_cnt = 0;

	fc_req_t dir_tab [22] = '{
		'{bef_pkg::REQ_WR_DST, 5'd31, 8'hff, 9'd0, 8'd0, 2'd0, 9'd0, 8'd0, 2'd0,
			1'b1, 8'h00, 9'd0},
		'{bef_pkg::REQ_RD_DST, 5'd31, 8'h00, 9'd0, 8'd0, 2'd0, 9'd0, 8'd0, 2'd0,
			1'b1, 8'hff, 9'd0},
		'{bef_pkg::REQ_WR_DST, 5'd0, 8'h00, 9'd0, 8'd0, 2'd0, 9'd0, 8'd0, 2'd0,
			1'b1, 8'h00, 9'd0},
		'{bef_pkg::REQ_RD_DST, 5'd0, 8'hff, 9'd0, 8'd0, 2'd0, 9'd0, 8'd0, 2'd0,
			1'b1, 8'h00, 9'd0},
		'{bef_pkg::REQ_WR_SRC, 5'd0, 8'hff, 9'd0, 8'd0, 2'd0, 9'd0, 8'd0, 2'd0,
			1'b1, 8'h00, 9'd0},
		'{bef_pkg::REQ_WR_SRC, 5'd31, 8'h00, 9'd0, 8'd0, 2'd0, 9'd0, 8'd0, 2'd0,
			1'b1, 8'h00, 9'd0},
		'{bef_pkg::REQ_COPY, 5'd0, 8'h00, 9'd256, 8'd0, 2'd0, 9'd256, 8'd0, 2'd0,
			1'b1, 8'h00, 9'd256},
		'{bef_pkg::REQ_COPY, 5'd0, 8'h00, 9'd256, 8'd0, 2'd3, 9'd256, 8'd0, 2'd3,
			1'b1, 8'h00, 9'd256},
		'{bef_pkg::REQ_COPY, 5'd0, 8'h00, 9'd10, 8'd20, 2'd0, 9'd100, 8'd0, 2'd0,
			1'b1, 8'h00, 9'd0},
		'{bef_pkg::REQ_COPY, 5'd0, 8'h00, 9'd40, 8'd40, 2'd1, 9'd100, 8'd3, 2'd2,
			1'b1, 8'h00, 9'd0},
		'{bef_pkg::REQ_COPY, 5'd0, 8'h00, 9'd60, 8'd0, 2'd2, 9'd0, 8'd0, 2'd0,
			1'b1, 8'h00, 9'd0},
		'{bef_pkg::REQ_COPY, 5'd0, 8'h00, 9'd256, 8'd250, 2'd3, 9'd256, 8'd255, 2'd1,
			1'b1, 8'h00, 9'd1},
		'{bef_pkg::REQ_COPY, 5'd0, 8'h00, 9'd24, 8'd3, 2'd2, 9'd16, 8'd5, 2'd0,
			1'b0, 8'h00, 9'd0},
		'{bef_pkg::REQ_COPY, 5'd0, 8'h00, 9'd20, 8'd2, 2'd1, 9'd30, 8'd7, 2'd0,
			1'b0, 8'h00, 9'd0},
		'{bef_pkg::REQ_COPY, 5'd0, 8'h00, 9'd17, 8'd1, 2'd0, 9'd64, 8'd9, 2'd2,
			1'b0, 8'h00, 9'd0},
		'{bef_pkg::REQ_COPY, 5'd0, 8'h00, 9'd256, 8'd255, 2'd2, 9'd9, 8'd1, 2'd1,
			1'b0, 8'h00, 9'd0},
		'{bef_pkg::REQ_COPY, 5'd0, 8'h00, 9'd33, 8'd4, 2'd3, 9'd41, 8'd11, 2'd2,
			1'b0, 8'h00, 9'd0},
		'{bef_pkg::REQ_RD_DST, 5'd1, 8'h00, 9'd0, 8'd0, 2'd0, 9'd0, 8'd0, 2'd0,
			1'b0, 8'h00, 9'd0},
		'{bef_pkg::REQ_RD_DST, 5'd2, 8'h00, 9'd0, 8'd0, 2'd0, 9'd0, 8'd0, 2'd0,
			1'b0, 8'h00, 9'd0},
		'{bef_pkg::REQ_RD_DST, 5'd4, 8'h00, 9'd0, 8'd0, 2'd0, 9'd0, 8'd0, 2'd0,
			1'b0, 8'h00, 9'd0},
		'{bef_pkg::REQ_RD_DST, 5'd5, 8'h00, 9'd0, 8'd0, 2'd0, 9'd0, 8'd0, 2'd0,
			1'b0, 8'h00, 9'd0},
		'{bef_pkg::REQ_RD_DST, 5'd31, 8'h00, 9'd0, 8'd0, 2'd0, 9'd0, 8'd0, 2'd0,
			1'b0, 8'h00, 9'd0}
	};

	bitwise_endian_field_copy i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.req_type    (req_type),
		.byte_index  (byte_index),
		.byte_data   (byte_data),
		.src_bits    (src_bits),
		.src_start   (src_start),
		.src_order   (src_order),
		.dst_bits    (dst_bits),
		.dst_start   (dst_start),
		.dst_order   (dst_order),
		.empty       (empty),
		.pop         (pop),
		.read_data   (read_data),
		.bits_copied (bits_copied)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// logical bit position to byte and bit in the store
	function automatic bit locate_bit(input int bits, input int pos, input logic [1:0] ord,
			output int byte_a, output int bit_a);
		int size;
		size = (bits + 7) / 8;
		byte_a = pos / 8;
		bit_a = pos % 8;
		if (ord[1]) bit_a = 7 - bit_a;
		if (ord[0]) byte_a = size - 1 - byte_a;
		return (pos >= 0 && pos < bits && byte_a >= 0 && byte_a < bef_pkg::BUF_BYTES);
	endfunction

	function automatic fc_result_t apply_request(input fc_req_t r);
		fc_result_t res;
		int sleft;
		int dleft;
		int n;
		int tpos;
		int sb;
		int sh;
		int db;
		int dh;
		bit rev;
		logic v;
		res = '0;
		case (r.req)
			bef_pkg::REQ_WR_SRC: src_mem[r.idx] = r.data;
			bef_pkg::REQ_WR_DST: dst_mem[r.idx] = r.data;
			bef_pkg::REQ_RD_DST: res.rd = dst_mem[r.idx];
			default: begin
				sleft = int'(r.sbits) - int'(r.sstart);
				dleft = int'(r.dbits) - int'(r.dstart);
				n = (sleft < dleft) ? sleft : dleft;
				if (n < 0) n = 0;
				rev = r.sord[1] != r.dord[1];
				for (int i = 0; i < n; i++) begin
					v = 1'b0;
					if (locate_bit(r.sbits, r.sstart + i, r.sord, sb, sh))
						v = src_mem[sb][sh];
					tpos = rev ? r.dstart + (sleft - 1 - i) : r.dstart + i;
					if (locate_bit(r.dbits, tpos, r.dord, db, dh))
						dst_mem[db][dh] = v;
				end
				res.nc = n[8:0];
			end
		endcase
		return res;
	endfunction

	task automatic send_req(input fc_req_t r);
		fc_result_t res;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
			repeat (gap) begin
				@(negedge clk);
				push = 1'b0;
				@(posedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(1, 30);
		end
		burst_left--;
		@(negedge clk);
		push = 1'b1;
		req_type = r.req;
		byte_index = r.idx;
		byte_data = r.data;
		src_bits = r.sbits;
		src_start = r.sstart;
		src_order = r.sord;
		dst_bits = r.dbits;
		dst_start = r.dstart;
		dst_order = r.dord;
		do @(posedge clk); while (full);
		res = apply_request(r);
		if (r.known) begin
			res.rd = r.rd;
			res.nc = r.nc;
		end
		pending_results.push_back(res);
	endtask

	task automatic drain_results();
		@(negedge clk);
		push = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	function automatic fc_req_t rand_req();
		fc_req_t r;
		int len;
		int st;
		int dl;
		int pick;
		r = '0;
		pick = $urandom_range(0, 99);
		if (pick < 25) r.req = bef_pkg::REQ_WR_SRC;
		else if (pick < 45) r.req = bef_pkg::REQ_WR_DST;
		else if (pick < 75) r.req = bef_pkg::REQ_COPY;
		else r.req = bef_pkg::REQ_RD_DST;
		r.idx = 5'($urandom);
		r.data = 8'($urandom);
		r.sbits = 9'($urandom_range(0, 256));
		r.sstart = 8'($urandom);
		r.sord = 2'($urandom);
		r.dbits = 9'($urandom_range(0, 256));
		r.dstart = 8'($urandom);
		r.dord = 2'($urandom);
		// short fields near the end of each array
		if (r.req == bef_pkg::REQ_COPY && $urandom_range(0, 9) < 8) begin
			len = $urandom_range(0, 12);
			st = (r.sbits > len) ? r.sbits - len : 0;
			r.sstart = (st > 255) ? 8'd255 : st[7:0];
			dl = $urandom_range(0, len + 4);
			st = (r.dbits > dl) ? r.dbits - dl : 0;
			r.dstart = (st > 255) ? 8'd255 : st[7:0];
		end
		return r;
	endfunction

	initial begin
		fc_req_t r;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		// load both stores in full
		for (int k = 0; k < 2 * bef_pkg::BUF_BYTES; k++) begin
			r = '0;
			r.req = (k < bef_pkg::BUF_BYTES) ? bef_pkg::REQ_WR_SRC : bef_pkg::REQ_WR_DST;
			r.idx = k[4:0];
			r.data = 8'($urandom);
			send_req(r);
		end
		foreach (dir_tab[k]) send_req(dir_tab[k]);
		drain_results();
		for (int k = 0; k < RAND_REQS; k++) begin
			if (k % 200 == 199) drain_results();
			send_req(rand_req());
		end
		drain_results();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("bitwise_endian_field_copy verification clean");
		else
			$display("bitwise_endian_field_copy verification failed");
		$finish;
	end

	// receiver stall pattern
	always @(negedge clk) begin
		mode_cnt++;
		if (mode_cnt >= 64) begin
			mode_cnt = 0;
			pop_mode = $urandom_range(0, 2);
		end
		if (stall_left > 0) begin
			stall_left--;
			pop = 1'b0;
		end else if ($urandom_range(0, 99) < 3) begin
			stall_left = $urandom_range(5, 30);
			pop = 1'b0;
		end else begin
			pop = (pop_mode == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
		end
	end

	always @(posedge clk) begin
		fc_result_t e;
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result read_data %h bits_copied %0d",
					$time, read_data, bits_copied);
			end else begin
				e = pending_results.pop_front();
				if (read_data !== e.rd) begin
					errors++;
					$display("%0t: read_data expected %h actual %h", $time, e.rd, read_data);
				end
				if (bits_copied !== e.nc) begin
					errors++;
					$display("%0t: bits_copied expected %0d actual %0d",
						$time, e.nc, bits_copied);
				end
			end
		end
	end

	// watchdog on cycles with no request or result moving
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("bitwise_endian_field_copy verification failed");
				$finish;
			end
		end
	end

endmodule
